[rtl/qvr_pkg.sv]
// Package with the types and constants shared by the quaternion vector rotator.
`timescale 1ns / 1ps
package qvr_pkg;

  // Fraction bits of the Q2.14 matrix entries.
  localparam int unsigned FracBits = 14;
  // Width of the raw quaternion components and of the input vector components.
  localparam int unsigned InW = 16;
  // Width of the rotated output components.
  localparam int unsigned OutW = 18;
  // Nine matrix entries, ten distinct quaternion products.
  localparam int unsigned NumEntries = 9;
  localparam int unsigned NumProducts = 10;
  // Identity value of a diagonal matrix entry.
  localparam logic signed [15:0] CoefOne = 16'sd16384;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } reg_idx_e;

  // States of the matrix calculation sequencer.
  typedef enum logic [2:0] {
    CALC_IDLE,
    CALC_MUL,
    CALC_NORM,
    CALC_LOAD,
    CALC_DIV
  } calc_state_e;

  typedef logic signed [15:0] coef_t;
  typedef coef_t coef_mat_t [NumEntries];

  // Status of the matrix calculation, seen by the vector datapath.
  typedef struct packed {
    logic busy;
    logic zero;
  } calc_status_t;

endpackage

[rtl/quaternion_vector_rotator.sv]
// Top level of the quaternion vector rotator: register port and vector pipeline.
`timescale 1ns / 1ps
// Rotates one 16-bit vector per clock while busy is low, by the matrix of the programmed quaternion.
// A vector is taken when start is high and busy is low; its result appears on
// rot_*_o with done_o high after the capture, product, row-sum and rounding
// registers, for a single cycle, and the receiver cannot stall it. Writing any
// quaternion register recomputes the matrix in a shared sequencer (ten products,
// the squared length, then for each of the nine entries a load and fifteen
// restoring division steps); busy stays high meanwhile, and a write during that
// time starts the sequence over. After reset the matrix is the identity.
// A quaternion of zero length passes vectors through and sets zero_quaternion_o.
module quaternion_vector_rotator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] vec_x_i,
  input  logic signed [15:0] vec_y_i,
  input  logic signed [15:0] vec_z_i,
  output logic               done_o,
  output logic signed [17:0] rot_x_o,
  output logic signed [17:0] rot_y_o,
  output logic signed [17:0] rot_z_o,
  output logic               zero_quaternion_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import qvr_pkg::*;

  logic signed [15:0] quat_q [4];
  logic               cfg_wr;
  reg_idx_e           cfg_idx;
  coef_mat_t          coef;
  calc_status_t       calc_st;

  logic               v1_q, v2_q, v3_q, v4_q;
  logic               z1_q, z2_q, z3_q;
  logic signed [15:0] vec1_q [3];
  logic signed [15:0] vec2_q [3];
  logic signed [15:0] vec3_q [3];
  logic signed [31:0] prd_q [NumEntries];
  logic signed [33:0] sum_q [3];
  logic signed [17:0] res_d [3];
  logic signed [17:0] res_q [3];
  logic               zo_q;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign prdata  = 32'(quat_q[cfg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q[REG_QUAT_W] <= CoefOne;
      quat_q[REG_QUAT_X] <= '0;
      quat_q[REG_QUAT_Y] <= '0;
      quat_q[REG_QUAT_Z] <= '0;
    end else if (cfg_wr) begin
      quat_q[cfg_idx] <= pwdata[15:0];
    end
  end

  qvr_matrix_calc u_calc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cfg_wr),
    .quat_w_i (quat_q[REG_QUAT_W]),
    .quat_x_i (quat_q[REG_QUAT_X]),
    .quat_y_i (quat_q[REG_QUAT_Y]),
    .quat_z_i (quat_q[REG_QUAT_Z]),
    .coef_o   (coef),
    .status_o (calc_st)
  );

  assign busy = calc_st.busy;

  // Valid bits of the four stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start & ~busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage one: capture the input transfer.
  always_ff @(posedge clk_i) begin
    vec1_q[0] <= vec_x_i;
    vec1_q[1] <= vec_y_i;
    vec1_q[2] <= vec_z_i;
    z1_q      <= calc_st.zero;
  end

  // Stage two: the nine products.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prd_q[3 * i + j] <= coef[3 * i + j] * vec1_q[j];
      end
    end
    vec2_q <= vec1_q;
    z2_q   <= z1_q;
  end

  // Stage three: row sums.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sum_q[i] <= 34'(prd_q[3 * i]) + 34'(prd_q[3 * i + 1]) + 34'(prd_q[3 * i + 2]);
    end
    vec3_q <= vec2_q;
    z3_q   <= z2_q;
  end

  // Stage four: round half up, saturate, or pass the vector through.
  always_comb begin
    logic signed [33:0] t;
    logic signed [19:0] r;
    for (int i = 0; i < 3; i++) begin
      t = sum_q[i] + 34'sd8192;
      r = 20'(t >>> FracBits);
      if (z3_q) begin
        res_d[i] = 18'(vec3_q[i]);
      end else if (r > 20'sd131071) begin
        res_d[i] = 18'sd131071;
      end else if (r < -20'sd131072) begin
        res_d[i] = -18'sd131072;
      end else begin
        res_d[i] = r[17:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    zo_q  <= z3_q;
  end

  assign done_o            = v4_q;
  assign rot_x_o           = res_q[0];
  assign rot_y_o           = res_q[1];
  assign rot_z_o           = res_q[2];
  assign zero_quaternion_o = zo_q;

endmodule

[rtl/qvr_matrix_calc.sv]
// Sequential unit that turns the quaternion into Q2.14 rotation matrix entries.
`timescale 1ns / 1ps
module qvr_matrix_calc (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [15:0]     quat_w_i,
  input  logic signed [15:0]     quat_x_i,
  input  logic signed [15:0]     quat_y_i,
  input  logic signed [15:0]     quat_z_i,
  output qvr_pkg::coef_mat_t     coef_o,
  output qvr_pkg::calc_status_t  status_o
);
  import qvr_pkg::*;

  calc_state_e state_q, state_d;

  logic [3:0]          prod_idx_q;
  logic [3:0]          ent_idx_q;
  logic [3:0]          bit_q;
  logic signed [31:0]  prod_q [NumProducts];
  logic [32:0]         n_q;
  logic                zero_q;
  logic [48:0]         rem_q;
  logic [14:0]         quo_q;
  logic                neg_q;
  coef_mat_t           coef_q;

  logic signed [15:0]  op_a, op_b;
  logic signed [31:0]  mul;
  logic signed [34:0]  num [NumEntries];
  logic signed [34:0]  num_sel;
  logic [33:0]         mag;
  logic [48:0]         div_sh;
  logic [49:0]         trial;
  logic                take;
  logic [14:0]         quo_fin;
  logic [32:0]         n_sum;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (prod_idx_q)
      4'd0: begin op_a = quat_w_i; op_b = quat_w_i; end
      4'd1: begin op_a = quat_x_i; op_b = quat_x_i; end
      4'd2: begin op_a = quat_y_i; op_b = quat_y_i; end
      4'd3: begin op_a = quat_z_i; op_b = quat_z_i; end
      4'd4: begin op_a = quat_x_i; op_b = quat_y_i; end
      4'd5: begin op_a = quat_x_i; op_b = quat_z_i; end
      4'd6: begin op_a = quat_y_i; op_b = quat_z_i; end
      4'd7: begin op_a = quat_w_i; op_b = quat_x_i; end
      4'd8: begin op_a = quat_w_i; op_b = quat_y_i; end
      4'd9: begin op_a = quat_w_i; op_b = quat_z_i; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign mul = op_a * op_b;

  // Squared length; each square is non-negative.
  assign n_sum = 33'(unsigned'(prod_q[0])) + 33'(unsigned'(prod_q[1]))
               + 33'(unsigned'(prod_q[2])) + 33'(unsigned'(prod_q[3]));

  // Matrix numerators from the stored products.
  always_comb begin
    num[0] = 35'(prod_q[0]) + 35'(prod_q[1]) - 35'(prod_q[2]) - 35'(prod_q[3]);
    num[1] = (35'(prod_q[4]) - 35'(prod_q[9])) <<< 1;
    num[2] = (35'(prod_q[5]) + 35'(prod_q[8])) <<< 1;
    num[3] = (35'(prod_q[4]) + 35'(prod_q[9])) <<< 1;
    num[4] = 35'(prod_q[0]) - 35'(prod_q[1]) + 35'(prod_q[2]) - 35'(prod_q[3]);
    num[5] = (35'(prod_q[6]) - 35'(prod_q[7])) <<< 1;
    num[6] = (35'(prod_q[5]) - 35'(prod_q[8])) <<< 1;
    num[7] = (35'(prod_q[6]) + 35'(prod_q[7])) <<< 1;
    num[8] = 35'(prod_q[0]) - 35'(prod_q[1]) - 35'(prod_q[2]) + 35'(prod_q[3]);
    num_sel = (ent_idx_q < 4'(NumEntries)) ? num[ent_idx_q] : '0;
    mag = num_sel[34] ? 34'(-num_sel) : 34'(num_sel);
  end

  // One restoring division step against twice the squared length.
  assign div_sh  = 49'({n_q, 1'b0}) << bit_q;
  assign trial   = {1'b0, rem_q} - {1'b0, div_sh};
  assign take    = ~trial[49];
  assign quo_fin = {quo_q[13:0], take};

  // Next state; a register write restarts the calculation from the first product.
  always_comb begin
    state_d = state_q;
    case (state_q)
      CALC_IDLE: if (start_i) state_d = CALC_MUL;
      CALC_MUL:  if (prod_idx_q == 4'(NumProducts - 1)) state_d = CALC_NORM;
      CALC_NORM: state_d = (n_sum == '0) ? CALC_IDLE : CALC_LOAD;
      CALC_LOAD: state_d = CALC_DIV;
      CALC_DIV: begin
        if (bit_q == '0) begin
          state_d = (ent_idx_q == 4'(NumEntries - 1)) ? CALC_IDLE : CALC_LOAD;
        end
      end
      default: state_d = CALC_IDLE;
    endcase
    if (start_i) state_d = CALC_MUL;
  end

  // Outputs.
  always_comb begin
    status_o.busy = (state_q != CALC_IDLE);
    status_o.zero = zero_q;
    coef_o        = coef_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CALC_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Counters and datapath registers; the matrix resets to identity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_idx_q <= '0;
      ent_idx_q  <= '0;
      bit_q      <= '0;
      zero_q     <= 1'b0;
      for (int i = 0; i < NumEntries; i++) begin
        coef_q[i] <= (i == 0 || i == 4 || i == 8) ? CoefOne : '0;
      end
    end else begin
      // The product counter starts over on every write.
      if (start_i) begin
        prod_idx_q <= '0;
      end else if (state_q == CALC_MUL) begin
        prod_idx_q <= prod_idx_q + 4'd1;
      end
      case (state_q)
        CALC_MUL: begin
          prod_q[prod_idx_q] <= mul;
        end
        CALC_NORM: begin
          n_q       <= n_sum;
          zero_q    <= (n_sum == '0);
          ent_idx_q <= '0;
        end
        CALC_LOAD: begin
          rem_q <= {mag, 15'b0} + 49'(n_q);
          neg_q <= num_sel[34];
          quo_q <= '0;
          bit_q <= 4'd14;
        end
        CALC_DIV: begin
          if (take) rem_q <= trial[48:0];
          quo_q <= quo_fin;
          bit_q <= bit_q - 4'd1;
          if (bit_q == '0) begin
            coef_q[ent_idx_q] <= neg_q ? -coef_t'({1'b0, quo_fin})
                                       : coef_t'({1'b0, quo_fin});
            ent_idx_q <= ent_idx_q + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/qvr_checker.sv]
// Port-level checker for the quaternion vector rotator and its bind.
`timescale 1ns / 1ps
module qvr_props (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic signed [17:0] rot_x_o,
  input logic               zero_quaternion_o,
  input logic               psel,
  input logic               penable,
  input logic               pwrite
);
  // Every accepted transfer gives a result at the end of the pipeline.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##4 done_o) else $error("result missing");

  // Every result comes from an earlier accepted transfer.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 4)) else $error("unexpected result");

  // A register write starts the matrix recalculation.
  a_recalc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=> busy) else $error("no recalculation");

  // A passed-through vector stays within 16-bit range.
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_quaternion_o |->
      (rot_x_o[17:15] == 3'b000 || rot_x_o[17:15] == 3'b111))
    else $error("pass-through out of range");
endmodule

bind quaternion_vector_rotator qvr_props u_qvr_props (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .done_o            (done_o),
  .rot_x_o           (rot_x_o),
  .zero_quaternion_o (zero_quaternion_o),
  .psel              (psel),
  .penable           (penable),
  .pwrite            (pwrite)
);
